>>> src/assert_macros.svh
// Assertion macros for the checker file of the lock manager.
// No dependencies; take in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mlmpi_pkg.sv
// Shared types and constants of the priority-inheritance lock manager.
// No dependencies; used by every module of the block.
`default_nettype none

package mlmpi_pkg;

    localparam int NUM_MUTEXES_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int PID_BITS_DEF    = 16;

    // Stream widths: input fields 66 bits padded to 72, result fields 32 bits.
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 32;
    localparam int PID_IO_W    = 16;
    localparam int SLOT_IO_W   = 4;
    localparam int EV_W        = 4;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_LOCK   = 2'd1,
        OP_UNLOCK = 2'd2,
        OP_RELALL = 2'd3
    } t_op;

    typedef enum logic [EV_W-1:0] {
        EV_GRANTED    = 4'd0,
        EV_BLOCKED    = 4'd1,
        EV_NO_MUTEX   = 4'd2,
        EV_NOT_OWNER  = 4'd3,
        EV_CREATED    = 4'd4,
        EV_RELEASED   = 4'd5,
        EV_PRIO       = 4'd6,
        EV_TABLE_FULL = 4'd7,
        EV_QUEUE_FULL = 4'd8
    } t_ev;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_FIND,
        DP_RST_IDX,
        DP_CREATE,
        DP_TAKE,
        DP_ENQ,
        DP_FREE,
        DP_HO_RD,
        DP_HO_WR,
        DP_EP_INIT,
        DP_EP_SLOT,
        DP_EP_RD,
        DP_EP_CMP,
        DP_NEXT,
        DP_REL_SLOT,
        DP_RESUME
    } t_dp_op;

    typedef enum logic {
        PI_REQ,
        PI_TP
    } t_pid_sel;

    typedef enum logic {
        PR_REQ,
        PR_BEST
    } t_prio_sel;

    typedef enum logic [1:0] {
        SL_ZERO,
        SL_CUR,
        SL_FREE
    } t_slot_sel;

    typedef struct packed {
        t_dp_op    dp_op;
        logic      emit;
        logic      flush;
        t_ev       ev;
        t_pid_sel  pid_sel;
        t_prio_sel prio_sel;
        t_slot_sel slot_sel;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        t_op  op;
        logic found;
        logic free_ok;
        logic owned;
        logic owner_is_req;
        logic q_full;
        logic q_empty;
        logic scan_hit;
        logic rel_hit;
        logic ep_hit;
        logic k_last;
        logic idx_last;
        logic cur_last;
    } t_sts;

endpackage

`default_nettype wire

>>> src/mutex_lock_manager_priority_inherit.sv
// Top level of the priority-inheritance mutex lock manager.
// Depends on mlmpi_pkg, mlmpi_ctrl and mlmpi_dp.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata: op, key, pid, prio, base
//  m_axis    out  m_axis_tvalid/tready    tdata: event, pid, prio, slot; tlast
//
// One request at a time. Key lookup walks the table one slot a cycle; each
// priority recalculation walks it again and reads each queued waiter of an
// owned mutex, one wait-queue entry per memory access. Release-all adds one
// table walk plus a recalculation per handed-over mutex.
// Reset (i_rst_n low, synchronous) empties the table at once.
// A stalled m_axis holds the result and the sequencer waits on it.
`default_nettype none

module mutex_lock_manager_priority_inherit #(
    parameter int NUM_MUTEXES = mlmpi_pkg::NUM_MUTEXES_DEF,
    parameter int QUEUE_DEPTH = mlmpi_pkg::QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = mlmpi_pkg::PID_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] operation, [33:2] mutex_key, [49:34] pid, [57:50] priority_req,
    // [65:58] base_priority, [71:66] zero
    input  logic [mlmpi_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [3:0] event_res, [19:4] event_pid, [27:20] new_priority, [31:28] slot
    output logic [mlmpi_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                              m_axis_tlast
);
    import mlmpi_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer: one state per step of a request.
    mlmpi_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Table, wait queues and the result registers.
    mlmpi_dp #(
        .NUM_MUTEXES (NUM_MUTEXES),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .PID_BITS    (PID_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

>>> src/mlmpi_ctrl.sv
// Controller state machine of the lock manager: sequences the table scans,
// hand-overs and priority recalculation. Depends on mlmpi_pkg.
`default_nettype none

module mlmpi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  mlmpi_pkg::t_sts   i_sts,
    output mlmpi_pkg::t_cmd   o_cmd
);
    import mlmpi_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE    = 15'b000000000000001,
        S_FIND    = 15'b000000000000010,
        S_DISP    = 15'b000000000000100,
        S_HO_RD   = 15'b000000000001000,
        S_HO_WR   = 15'b000000000010000,
        S_EP_SLOT = 15'b000000000100000,
        S_EP_RD   = 15'b000000001000000,
        S_EP_CMP  = 15'b000000010000000,
        S_EP_NEXT = 15'b000000100000000,
        S_EP_DONE = 15'b000001000000000,
        S_EP_REQ  = 15'b000010000000000,
        S_REL     = 15'b000100000000000,
        S_REL_HIT = 15'b001000000000000,
        S_REL_RES = 15'b010000000000000,
        S_FLUSH   = 15'b100000000000000
    } t_state;

    // What follows a priority recalculation.
    typedef enum logic [1:0] {
        C_LOCK,
        C_UNLK,
        C_GRANT
    } t_ctx;

    t_state r_state, n_state;
    t_ctx   r_ctx, n_ctx;

    assign o_s_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ctx   <= C_LOCK;
        end else begin
            r_state <= n_state;
            r_ctx   <= n_ctx;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_ctx          = r_ctx;
        o_cmd.dp_op    = DP_NOP;
        o_cmd.emit     = 1'b0;
        o_cmd.flush    = 1'b0;
        o_cmd.ev       = EV_GRANTED;
        o_cmd.pid_sel  = PI_REQ;
        o_cmd.prio_sel = PR_REQ;
        o_cmd.slot_sel = SL_CUR;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.dp_op = DP_LOAD;
                    n_state     = S_FIND;
                end
            end
            S_FIND: begin
                if (i_sts.op == OP_RELALL) begin
                    o_cmd.dp_op = DP_RST_IDX;
                    n_state     = S_REL;
                end else begin
                    o_cmd.dp_op = DP_FIND;
                    if (i_sts.scan_hit || i_sts.idx_last) begin
                        n_state = S_DISP;
                    end
                end
            end
            S_DISP: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_FLUSH;
                    unique case (i_sts.op)
                        OP_CREATE: begin
                            if (i_sts.found) begin
                                o_cmd.ev = EV_CREATED;
                            end else if (i_sts.free_ok) begin
                                o_cmd.dp_op    = DP_CREATE;
                                o_cmd.ev       = EV_CREATED;
                                o_cmd.slot_sel = SL_FREE;
                            end else begin
                                o_cmd.ev       = EV_TABLE_FULL;
                                o_cmd.slot_sel = SL_ZERO;
                            end
                        end
                        OP_LOCK: begin
                            if (!i_sts.found) begin
                                o_cmd.ev       = EV_NO_MUTEX;
                                o_cmd.slot_sel = SL_ZERO;
                            end else if (!i_sts.owned) begin
                                o_cmd.dp_op = DP_TAKE;
                                o_cmd.ev    = EV_GRANTED;
                            end else if (i_sts.q_full) begin
                                o_cmd.ev = EV_QUEUE_FULL;
                            end else begin
                                o_cmd.dp_op = DP_ENQ;
                                o_cmd.ev    = EV_BLOCKED;
                                n_ctx       = C_LOCK;
                                n_state     = S_EP_SLOT;
                            end
                        end
                        OP_UNLOCK: begin
                            if (!i_sts.found) begin
                                o_cmd.ev       = EV_NO_MUTEX;
                                o_cmd.slot_sel = SL_ZERO;
                            end else if (!i_sts.owned || !i_sts.owner_is_req) begin
                                o_cmd.ev = EV_NOT_OWNER;
                            end else if (i_sts.q_empty) begin
                                o_cmd.dp_op = DP_FREE;
                                o_cmd.ev    = EV_RELEASED;
                                n_state     = S_EP_REQ;
                            end else begin
                                o_cmd.ev = EV_RELEASED;
                                n_state  = S_HO_RD;
                            end
                        end
                        OP_RELALL: begin
                            o_cmd.emit = 1'b0;
                        end
                        default: begin
                            o_cmd.emit = 1'b0;
                        end
                    endcase
                end
            end
            S_HO_RD: begin
                o_cmd.dp_op = DP_HO_RD;
                n_state     = S_HO_WR;
            end
            S_HO_WR: begin
                o_cmd.dp_op = DP_HO_WR;
                n_ctx       = C_GRANT;
                n_state     = S_EP_SLOT;
            end
            S_EP_SLOT: begin
                o_cmd.dp_op = DP_EP_SLOT;
                if (i_sts.ep_hit) begin
                    n_state = S_EP_RD;
                end else if (i_sts.idx_last) begin
                    n_state = S_EP_DONE;
                end
            end
            S_EP_RD: begin
                o_cmd.dp_op = DP_EP_RD;
                n_state     = S_EP_CMP;
            end
            S_EP_CMP: begin
                o_cmd.dp_op = DP_EP_CMP;
                if (!i_sts.k_last) begin
                    n_state = S_EP_RD;
                end else if (i_sts.idx_last) begin
                    n_state = S_EP_DONE;
                end else begin
                    n_state = S_EP_NEXT;
                end
            end
            S_EP_NEXT: begin
                o_cmd.dp_op = DP_NEXT;
                n_state     = S_EP_SLOT;
            end
            S_EP_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.pid_sel  = PI_TP;
                    o_cmd.prio_sel = PR_BEST;
                    unique case (r_ctx)
                        C_LOCK, C_UNLK: begin
                            o_cmd.ev = EV_PRIO;
                            n_state  = S_FLUSH;
                        end
                        C_GRANT: begin
                            o_cmd.ev = EV_GRANTED;
                            n_state  = (i_sts.op == OP_UNLOCK) ? S_EP_REQ : S_REL_RES;
                        end
                        default: begin
                            n_state = S_FLUSH;
                        end
                    endcase
                end
            end
            S_EP_REQ: begin
                o_cmd.dp_op = DP_EP_INIT;
                n_ctx       = C_UNLK;
                n_state     = S_EP_SLOT;
            end
            S_REL: begin
                o_cmd.dp_op = DP_REL_SLOT;
                if (i_sts.rel_hit) begin
                    n_state = S_REL_HIT;
                end else if (i_sts.idx_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_REL_HIT: begin
                if (!i_sts.q_empty) begin
                    n_state = S_HO_RD;
                end else if (i_sts.out_free) begin
                    o_cmd.dp_op = DP_FREE;
                    o_cmd.emit  = 1'b1;
                    o_cmd.ev    = EV_RELEASED;
                    n_state     = S_REL_RES;
                end
            end
            S_REL_RES: begin
                o_cmd.dp_op = DP_RESUME;
                n_state     = i_sts.cur_last ? S_FLUSH : S_REL;
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/mlmpi_dp.sv
// Datapath of the lock manager: mutex table, wait-queue memory, working
// registers and the result staging/output registers. Depends on mlmpi_pkg.
`default_nettype none

module mlmpi_dp #(
    parameter int NUM_MUTEXES = mlmpi_pkg::NUM_MUTEXES_DEF,
    parameter int QUEUE_DEPTH = mlmpi_pkg::QUEUE_DEPTH_DEF,
    parameter int PID_BITS    = mlmpi_pkg::PID_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [mlmpi_pkg::IN_TDATA_W-1:0]   i_in_data,
    input  mlmpi_pkg::t_cmd                    i_cmd,
    output mlmpi_pkg::t_sts                    o_sts,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [mlmpi_pkg::OUT_TDATA_W-1:0]  o_out_data,
    output logic                               o_out_last
);
    import mlmpi_pkg::*;

    localparam int SW = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int IW = $clog2(NUM_MUTEXES + 1);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int EW = PID_BITS + 16;

    // head + count, wrapped; both operands stay below the depth (count may equal it)
    function automatic logic [QW-1:0] f_wrap(input logic [QW-1:0] a, input logic [CW-1:0] b);
        logic [CW:0] sum;
        sum = (CW+1)'(a) + (CW+1)'(b);
        if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CW+1)'(QUEUE_DEPTH);
        end
        return sum[QW-1:0];
    endfunction

    // mutex table
    logic                r_used     [NUM_MUTEXES];
    logic [31:0]         r_slot_key [NUM_MUTEXES];
    logic                r_own_v    [NUM_MUTEXES];
    logic [PID_BITS-1:0] r_own_pid  [NUM_MUTEXES];
    logic [7:0]          r_own_base [NUM_MUTEXES];
    logic [QW-1:0]       r_qhead    [NUM_MUTEXES];
    logic [CW-1:0]       r_qcnt     [NUM_MUTEXES];
    // wait queues: {pid, snapshot priority, base}
    logic [EW-1:0]       r_wmem     [NUM_MUTEXES][QUEUE_DEPTH];
    logic [EW-1:0]       r_rdata;

    // request and working registers
    t_op                 r_op;
    logic [31:0]         r_key;
    logic [PID_BITS-1:0] r_pid;
    logic [7:0]          r_prio;
    logic [7:0]          r_base;
    logic [IW-1:0]       r_i;
    logic [SW-1:0]       r_s;
    logic [SW-1:0]       r_free;
    logic                r_found;
    logic                r_free_ok;
    logic                r_ov;
    logic [PID_BITS-1:0] r_opid;
    logic [7:0]          r_obase;
    logic [QW-1:0]       r_head;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_k;
    logic [PID_BITS-1:0] r_tp;
    logic [7:0]          r_best;

    // result staging and output
    logic                   r_pv;
    logic [OUT_TDATA_W-1:0] r_pend;
    logic                   r_out_v;
    logic [OUT_TDATA_W-1:0] r_out;
    logic                   r_out_last;

    logic [SW-1:0]          idx;
    logic [SW-1:0]          wr_slot;
    logic [SW-1:0]          rd_slot;
    logic [QW-1:0]          rd_pos;
    logic                   rd_en;
    logic                   scan_hit;
    logic                   rel_hit;
    logic                   ep_hit;
    logic                   out_free;
    logic [PID_BITS-1:0]    ev_pid;
    logic [7:0]             ev_prio;
    logic [SW-1:0]          ev_slot;
    logic [OUT_TDATA_W-1:0] ev_word;
    logic [OUT_TDATA_W-1:0] dflt_word;

    assign idx      = r_i[SW-1:0];
    assign scan_hit = r_used[idx] && (r_slot_key[idx] == r_key);
    assign rel_hit  = r_used[idx] && r_own_v[idx] && (r_own_pid[idx] == r_pid);
    assign ep_hit   = r_used[idx] && r_own_v[idx] && (r_own_pid[idx] == r_tp)
                      && (r_qcnt[idx] != '0);
    assign out_free = !r_out_v || i_out_ready;

    assign o_sts.out_free     = out_free;
    assign o_sts.op           = r_op;
    assign o_sts.found        = r_found;
    assign o_sts.free_ok      = r_free_ok;
    assign o_sts.owned        = r_ov;
    assign o_sts.owner_is_req = (r_opid == r_pid);
    assign o_sts.q_full       = (r_cnt >= CW'(QUEUE_DEPTH));
    assign o_sts.q_empty      = (r_cnt == '0);
    assign o_sts.scan_hit     = scan_hit;
    assign o_sts.rel_hit      = rel_hit;
    assign o_sts.ep_hit       = ep_hit;
    assign o_sts.k_last       = (({1'b0, r_k} + 1'b1) == {1'b0, r_cnt});
    assign o_sts.idx_last     = (r_i == IW'(NUM_MUTEXES - 1));
    assign o_sts.cur_last     = (r_s == SW'(NUM_MUTEXES - 1));

    assign wr_slot = (i_cmd.dp_op == DP_CREATE) ? r_free : r_s;
    assign rd_en   = (i_cmd.dp_op == DP_HO_RD) || (i_cmd.dp_op == DP_EP_RD);
    assign rd_slot = (i_cmd.dp_op == DP_HO_RD) ? r_s : idx;
    assign rd_pos  = (i_cmd.dp_op == DP_HO_RD) ? r_head : f_wrap(r_head, r_k);

    // result word
    always_comb begin
        ev_pid  = (i_cmd.pid_sel == PI_TP) ? r_tp : r_pid;
        ev_prio = (i_cmd.prio_sel == PR_BEST) ? r_best : r_prio;
        case (i_cmd.slot_sel)
            SL_CUR:  ev_slot = r_s;
            SL_FREE: ev_slot = r_free;
            default: ev_slot = '0;
        endcase
        ev_word   = {SLOT_IO_W'(ev_slot), ev_prio, PID_IO_W'(ev_pid), i_cmd.ev};
        dflt_word = {SLOT_IO_W'(0), r_prio, PID_IO_W'(r_pid), EV_RELEASED};
    end

    // table entries with a defined reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_MUTEXES; j++) begin
                r_used[j]  <= 1'b0;
                r_own_v[j] <= 1'b0;
                r_qhead[j] <= '0;
                r_qcnt[j]  <= '0;
            end
        end else begin
            case (i_cmd.dp_op)
                DP_CREATE: begin
                    r_used[wr_slot]  <= 1'b1;
                    r_own_v[wr_slot] <= 1'b0;
                    r_qhead[wr_slot] <= '0;
                    r_qcnt[wr_slot]  <= '0;
                end
                DP_TAKE: begin
                    r_own_v[wr_slot] <= 1'b1;
                end
                DP_ENQ: begin
                    r_qcnt[wr_slot] <= r_cnt + 1'b1;
                end
                DP_FREE: begin
                    r_own_v[wr_slot] <= 1'b0;
                end
                DP_HO_WR: begin
                    r_own_v[wr_slot] <= 1'b1;
                    r_qhead[wr_slot] <= f_wrap(r_head, CW'(1));
                    r_qcnt[wr_slot]  <= r_cnt - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // table payload, queue memory and working registers
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_wmem[rd_slot][rd_pos];
        end
        case (i_cmd.dp_op)
            DP_LOAD: begin
                r_op      <= t_op'(i_in_data[1:0]);
                r_key     <= i_in_data[33:2];
                r_pid     <= PID_BITS'(i_in_data[49:34]);
                r_prio    <= i_in_data[57:50];
                r_base    <= i_in_data[65:58];
                r_i       <= '0;
                r_found   <= 1'b0;
                r_free_ok <= 1'b0;
            end
            DP_FIND: begin
                if (scan_hit) begin
                    r_found <= 1'b1;
                    r_s     <= idx;
                    r_ov    <= r_own_v[idx];
                    r_opid  <= r_own_pid[idx];
                    r_obase <= r_own_base[idx];
                    r_head  <= r_qhead[idx];
                    r_cnt   <= r_qcnt[idx];
                end
                if (!r_used[idx] && !r_free_ok) begin
                    r_free    <= idx;
                    r_free_ok <= 1'b1;
                end
                r_i <= r_i + 1'b1;
            end
            DP_RST_IDX: begin
                r_i <= '0;
            end
            DP_CREATE: begin
                r_slot_key[wr_slot] <= r_key;
            end
            DP_TAKE: begin
                r_own_pid[wr_slot]  <= r_pid;
                r_own_base[wr_slot] <= r_base;
            end
            DP_ENQ: begin
                r_wmem[wr_slot][f_wrap(r_head, r_cnt)] <= {r_pid, r_prio, r_base};
                r_tp   <= r_opid;
                r_best <= r_obase;
                r_i    <= '0;
            end
            DP_HO_WR: begin
                r_own_pid[wr_slot]  <= r_rdata[EW-1:16];
                r_own_base[wr_slot] <= r_rdata[7:0];
                r_tp                <= r_rdata[EW-1:16];
                r_best              <= r_rdata[7:0];
                r_i                 <= '0;
            end
            DP_EP_INIT: begin
                r_tp   <= r_pid;
                r_best <= r_base;
                r_i    <= '0;
            end
            DP_EP_SLOT: begin
                if (ep_hit) begin
                    r_head <= r_qhead[idx];
                    r_cnt  <= r_qcnt[idx];
                    r_k    <= '0;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            DP_EP_CMP: begin
                if (r_rdata[15:8] < r_best) begin
                    r_best <= r_rdata[15:8];
                end
                r_k <= r_k + 1'b1;
            end
            DP_NEXT: begin
                r_i <= r_i + 1'b1;
            end
            DP_REL_SLOT: begin
                if (rel_hit) begin
                    r_s    <= idx;
                    r_head <= r_qhead[idx];
                    r_cnt  <= r_qcnt[idx];
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            DP_RESUME: begin
                r_i <= IW'(r_s) + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Hold one result back so the final one can carry last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cmd.flush) begin
                r_out      <= r_pv ? r_pend : dflt_word;
                r_out_last <= 1'b1;
                r_out_v    <= 1'b1;
                r_pv       <= 1'b0;
            end else if (i_cmd.emit && r_pv) begin
                r_out      <= r_pend;
                r_out_last <= 1'b0;
                r_out_v    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_pend <= ev_word;
                r_pv   <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

>>> src/mlmpi_checker.sv
// Port-level checks of the lock manager, bound to the top level.
// Depends on assert_macros.svh and mlmpi_pkg.
`default_nettype none
`include "assert_macros.svh"

module mlmpi_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_axis_tvalid,
    input logic                              s_axis_tready,
    input logic [mlmpi_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [mlmpi_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                              m_axis_tlast
);
    logic unused_in;
    assign unused_in = ^s_axis_tdata;

    // a transfer in starts work: no second request straight after
    `ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && !unused_in ||
        s_axis_tvalid && s_axis_tready && unused_in, !s_axis_tready, "ready held after a transfer")

    // ready comes back only with the final result of the request on the output
    `ASSERT_SAME(a_ready_after_last, i_clk, i_rst_n, $rose(s_axis_tready),
        m_axis_tvalid && m_axis_tlast, "ready returned before final result")

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result changed")

    // event codes stop at queue full
    `ASSERT_SAME(a_event_range, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[3:0] <= 4'd8, "event code out of range")

endmodule

bind mutex_lock_manager_priority_inherit mlmpi_checker u_mlmpi_checker (.*);

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for the priority-inheritance mutex lock manager.
// Depends on mlmpi_pkg and mutex_lock_manager_priority_inherit; predicts every
// result from an internal model of the mutex table and checks the output stream.
`timescale 1ns / 1ps

module tb;
    import mlmpi_pkg::*;

    localparam int NSLOT  = 16;
    localparam int QDEPTH = 8;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic [3:0]  ev;
        logic [15:0] pid;
        logic [7:0]  prio;
        logic [3:0]  slot;
        logic        last;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [1:0] op, [33:2] key, [49:34] pid, [57:50] prio, [65:58] base, [71:66] zero
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] event, [19:4] pid, [27:20] new priority, [31:28] slot
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    mutex_lock_manager_priority_inherit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mirror of the mutex table
    logic        tbl_used [NSLOT];
    logic [31:0] tbl_key  [NSLOT];
    logic        tbl_held [NSLOT];
    logic [15:0] tbl_owner[NSLOT];
    logic [7:0]  tbl_base [NSLOT];
    logic [15:0] wq_pid [NSLOT][QDEPTH];
    logic [7:0]  wq_prio[NSLOT][QDEPTH];
    logic [7:0]  wq_base[NSLOT][QDEPTH];
    int          wq_head[NSLOT];
    int          wq_cnt [NSLOT];

    t_event expected_events[$];
    int     errors = 0;
    int     n_sent = 0;
    int     n_checked = 0;
    int     idle_cycles = 0;
    logic   hold_sink = 1'b0;
    logic   free_run_sink = 1'b0;
    logic   burst_mode = 1'b1;
    // Keys the stimulus draws from; the first 16 get created early so most requests hit
    logic [31:0] key_pool[20];

    function automatic void push_event(t_ev ev, logic [15:0] pid, logic [7:0] prio,
                                       int slot);
        t_event e;
        e.ev = ev; e.pid = pid; e.prio = prio; e.slot = slot[3:0]; e.last = 1'b0;
        expected_events.push_back(e);
    endfunction

    function automatic logic [7:0] inherited_prio(logic [15:0] pid, logic [7:0] base);
        logic [7:0] best;
        best = base;
        for (int s = 0; s < NSLOT; s++)
            if (tbl_used[s] && tbl_held[s] && tbl_owner[s] == pid)
                for (int k = 0; k < wq_cnt[s]; k++)
                    if (wq_prio[s][(wq_head[s] + k) % QDEPTH] < best)
                        best = wq_prio[s][(wq_head[s] + k) % QDEPTH];
        return best;
    endfunction

    // Hand slot s to its queue head; returns 1 when a grant was issued
    function automatic bit pass_ownership(int s);
        int h;
        if (wq_cnt[s] == 0) begin
            tbl_held[s] = 1'b0;
            return 0;
        end
        h = wq_head[s];
        wq_head[s] = (h + 1) % QDEPTH;
        wq_cnt[s]--;
        tbl_held[s] = 1'b1;
        tbl_owner[s] = wq_pid[s][h];
        tbl_base[s] = wq_base[s][h];
        push_event(EV_GRANTED, wq_pid[s][h], inherited_prio(wq_pid[s][h], wq_base[s][h]), s);
        return 1;
    endfunction

    function automatic void predict_request(t_op op, logic [31:0] key, logic [15:0] pid,
                                            logic [7:0] prio, logic [7:0] base);
        int s;
        int first;
        int pos;
        t_event e;
        first = expected_events.size();
        s = -1;
        for (int i = 0; i < NSLOT; i++)
            if (s < 0 && tbl_used[i] && tbl_key[i] == key) s = i;
        case (op)
            OP_CREATE: begin
                if (s < 0) begin
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (!tbl_used[i]) s = i;
                    if (s < 0) push_event(EV_TABLE_FULL, pid, prio, 0);
                    else begin
                        tbl_used[s] = 1'b1; tbl_key[s] = key; tbl_held[s] = 1'b0;
                        wq_head[s] = 0; wq_cnt[s] = 0;
                        push_event(EV_CREATED, pid, prio, s);
                    end
                end else push_event(EV_CREATED, pid, prio, s);
            end
            OP_LOCK: begin
                if (s < 0) push_event(EV_NO_MUTEX, pid, prio, 0);
                else if (!tbl_held[s]) begin
                    tbl_held[s] = 1'b1; tbl_owner[s] = pid; tbl_base[s] = base;
                    push_event(EV_GRANTED, pid, prio, s);
                end else if (wq_cnt[s] >= QDEPTH) push_event(EV_QUEUE_FULL, pid, prio, s);
                else begin
                    pos = (wq_head[s] + wq_cnt[s]) % QDEPTH;
                    wq_pid[s][pos] = pid; wq_prio[s][pos] = prio; wq_base[s][pos] = base;
                    wq_cnt[s]++;
                    push_event(EV_BLOCKED, pid, prio, s);
                    push_event(EV_PRIO, tbl_owner[s],
                               inherited_prio(tbl_owner[s], tbl_base[s]), s);
                end
            end
            OP_UNLOCK: begin
                if (s < 0) push_event(EV_NO_MUTEX, pid, prio, 0);
                else if (!tbl_held[s] || tbl_owner[s] != pid)
                    push_event(EV_NOT_OWNER, pid, prio, s);
                else begin
                    push_event(EV_RELEASED, pid, prio, s);
                    void'(pass_ownership(s));
                    push_event(EV_PRIO, pid, inherited_prio(pid, base), s);
                end
            end
            default: begin
                for (int i = 0; i < NSLOT; i++)
                    if (tbl_used[i] && tbl_held[i] && tbl_owner[i] == pid)
                        if (!pass_ownership(i)) push_event(EV_RELEASED, pid, prio, i);
                if (expected_events.size() == first) push_event(EV_RELEASED, pid, prio, 0);
            end
        endcase
        e = expected_events[$];
        e.last = 1'b1;
        expected_events[$] = e;
    endfunction

    // Offer one request, hold it until the transfer, predict on acceptance
    task automatic send_request(t_op op, logic [31:0] key, logic [15:0] pid,
                                logic [7:0] prio, logic [7:0] base);
        int gap;
        // step off the edge that dropped valid for the previous request
        @(posedge i_clk);
        if (burst_mode && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 12);
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata <= {6'd0, base, prio, pid, key, op};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(op, key, pid, prio, base);
        n_sent++;
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain_results();
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Receiver: own stall pattern, forced open or closed by the test phases
    always @(posedge i_clk) begin
        if (hold_sink) m_axis_tready <= 1'b0;
        else if (free_run_sink) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 9) > 2);
    end

    // Check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_event act;
        t_event exp_ev;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            act = {m_axis_tdata[3:0], m_axis_tdata[19:4], m_axis_tdata[27:20],
                   m_axis_tdata[31:28], m_axis_tlast};
            if (expected_events.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, act);
                errors++;
            end else begin
                exp_ev = expected_events.pop_front();
                if (act !== exp_ev) begin
                    $display("%0t: mismatch ev/pid/prio/slot/last expected %h %h %h %h %b",
                             $time, exp_ev.ev, exp_ev.pid, exp_ev.prio, exp_ev.slot,
                             exp_ev.last);
                    $display("%0t:                         actual   %h %h %h %h %b",
                             $time, act.ev, act.pid, act.prio, act.slot, act.last);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    // Watchdog: count cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Extremes, every operation, table full, relock by owner
    task automatic test_directed();
        send_request(OP_LOCK, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF);      // unknown key
        send_request(OP_UNLOCK, 32'h0, 16'h0, 8'h0, 8'h0);                 // unknown key
        send_request(OP_RELALL, 32'h0, 16'h0, 8'h12, 8'h0);                // holds nothing
        for (int i = 0; i < NSLOT; i++)
            send_request(OP_CREATE, key_pool[i], 16'(i), 8'(i), 8'(i));
        send_request(OP_CREATE, key_pool[16], 16'h1, 8'h0, 8'h0);          // table full
        send_request(OP_CREATE, key_pool[0], 16'h1, 8'h0, 8'h0);           // exists
        send_request(OP_LOCK, key_pool[0], 16'hFFFF, 8'hFF, 8'hFF);
        send_request(OP_LOCK, key_pool[0], 16'hFFFF, 8'h80, 8'hF0);        // relock by owner
        send_request(OP_UNLOCK, key_pool[0], 16'h5555, 8'h10, 8'h10);      // not owner
        send_request(OP_UNLOCK, key_pool[1], 16'hFFFF, 8'h10, 8'h10);      // free: not owner
    endtask

    task automatic test_queue_full();
        send_request(OP_LOCK, key_pool[2], 16'h0, 8'h40, 8'h40);
        for (int i = 0; i < QDEPTH + 1; i++)
            send_request(OP_LOCK, key_pool[2], 16'(16'hAAAA + i), 8'(8'h30 - i), 8'h00);
        send_request(OP_UNLOCK, key_pool[2], 16'h0, 8'h40, 8'h40);
        send_request(OP_RELALL, 32'h0, 16'hFFFF, 8'h00, 8'h00);
        send_request(OP_RELALL, 32'h0, 16'hAAAA, 8'hFF, 8'hFF);
    endtask

    // Hold the receiver shut while requests keep coming, then let it drain
    task automatic test_backpressure();
        fork
            begin
                hold_sink = 1'b1;
                repeat (400) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 8; i++)
                send_request(OP_LOCK, key_pool[3], 16'(i % 3), 8'($urandom), 8'($urandom));
        join
        drain_results();
    endtask

    task automatic test_random(int count);
        t_op op;
        logic [15:0] pid;
        logic [31:0] key;
        for (int i = 0; i < count; i++) begin
            if (i == count / 2) begin
                burst_mode = 1'b0;
                free_run_sink = 1'b1;
            end
            if (i == count * 3 / 4) begin
                burst_mode = 1'b1;
                free_run_sink = 1'b0;
            end
            op = t_op'($urandom_range(0, 3));
            if ($urandom_range(0, 9) < 4 && op == OP_RELALL) op = OP_UNLOCK;
            pid = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
            key = ($urandom_range(0, 14) == 0) ? $urandom : key_pool[$urandom_range(0, 19)];
            send_request(op, key, pid, 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tbl_used[i] = 1'b0; tbl_held[i] = 1'b0; wq_head[i] = 0; wq_cnt[i] = 0;
            tbl_key[i] = '0; tbl_owner[i] = '0; tbl_base[i] = '0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 20; i++) key_pool[i] = $urandom;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_queue_full();
        drain_results();
        test_backpressure();
        test_random(120);
        drain_results();
        $display("Covered %0d requests and %0d result transfers: create, lock, unlock,",
                 n_sent, n_checked);
        $display("release-all, full table and queue, inheritance and stalled output.");
        if (errors == 0 && expected_events.size() == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
